[hw/rtl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, types and the pulse-width mapping for the frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam int BODY_LEN  = 24;
	localparam int NUM_CH    = 16;
	localparam int RAW_W     = 11;
	localparam int ACC_W     = 18;   // up to 10 left-over bits plus one byte
	localparam int CNT_W     = 5;

	localparam logic [7:0] HDR_BYTE = 8'h0F;
	localparam logic [7:0] FOOT_A   = 8'h00;
	localparam logic [7:0] FOOT_B   = 8'h04;

	localparam logic [4:0] LAST_BODY = 5'd23;
	localparam logic [3:0] LAST_CH   = 4'd15;

	localparam logic [10:0] RAW_LO   = 11'd192;
	localparam logic [10:0] RAW_HI   = 11'd1792;
	localparam logic [10:0] PW_BASE  = 11'd1000;
	localparam logic [10:0] PW_TOP   = 11'd2000;

	typedef enum logic [2:0] {
		ST_HUNT    = 3'b001,
		ST_COLLECT = 3'b010,
		ST_DRAIN   = 3'b100
	} state_t;

	// status handed from the unpacker to the frame control
	typedef struct packed {
		logic busy;
		logic shift;
		logic done;
	} unpack_stat_t;

	function automatic logic [10:0] pulse_of(input logic [10:0] raw);
		logic [10:0] c;
		logic [10:0] d;
		logic [13:0] m;
		c = raw;
		if (c < RAW_LO) c = RAW_LO;
		if (c > RAW_HI) c = RAW_HI;
		d = c - RAW_LO;
		m = {3'b000, d} * 14'd5;
		return m[13:3] + PW_BASE;
	endfunction

endpackage

[hw/rtl/sfd_in_if.sv]
// ----------------------------------------------------------------------------
// sfd_in_if
// Receive-byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface sfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

[hw/rtl/sfd_out_if.sv]
// ----------------------------------------------------------------------------
// sfd_out_if
// Channel result channel: valid/ready handshake with one decoded channel.
// ----------------------------------------------------------------------------
interface sfd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel_index;
	logic [10:0] raw_value;
	logic [10:0] pulse_width;
	logic        lost_flag;
	logic        failsafe;
	logic        last;

	modport source (output valid, output channel_index, output raw_value,
		output pulse_width, output lost_flag, output failsafe, output last,
		input ready);
	modport sink   (input valid, input channel_index, input raw_value,
		input pulse_width, input lost_flag, input failsafe, input last,
		output ready);
endinterface

[hw/rtl/sfd_byte_cell.sv]
// ----------------------------------------------------------------------------
// sfd_byte_cell
// One byte of the frame chain: takes its neighbor's byte on each shift.
// ----------------------------------------------------------------------------
module sfd_byte_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	output logic [7:0] dout
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

endmodule

[hw/rtl/sfd_unpack.sv]
// ----------------------------------------------------------------------------
// sfd_unpack
// Bit accumulator at the head of the chain: pulls bytes, emits 11-bit channels.
// ----------------------------------------------------------------------------
module sfd_unpack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [7:0]            flags,
	input  logic [7:0]            head_byte,
	output sfd_pkg::unpack_stat_t stat,
	sfd_out_if.source             res
);

	logic [sfd_pkg::ACC_W-1:0] acc_q;
	logic [sfd_pkg::CNT_W-1:0] cnt_q;
	logic [3:0]                ch_q;
	logic                      busy_q;
	logic                      lost_q;
	logic                      fs_q;
	logic                      ov_q;

	logic [3:0]  och_q;
	logic [10:0] oraw_q;
	logic [10:0] opw_q;
	logic        olost_q;
	logic        ofs_q;
	logic        olast_q;

	logic have_bits;
	logic can_emit;
	logic load;
	logic [sfd_pkg::ACC_W-1:0] byte_ext;

	assign have_bits = cnt_q >= sfd_pkg::CNT_W'(sfd_pkg::RAW_W);
	assign can_emit  = busy_q && have_bits && (!ov_q || res.ready);
	assign load      = busy_q && !have_bits;
	assign byte_ext  = {{(sfd_pkg::ACC_W-8){1'b0}}, head_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
			cnt_q  <= '0;
			ch_q   <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				ch_q   <= '0;
			end else if (can_emit) begin
				cnt_q <= cnt_q - sfd_pkg::CNT_W'(sfd_pkg::RAW_W);
				ch_q  <= ch_q + 4'd1;
				if (ch_q == sfd_pkg::LAST_CH) begin
					busy_q <= 1'b0;
				end
			end else if (load) begin
				cnt_q <= cnt_q + 5'd8;
			end
			if (can_emit) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			lost_q <= flags[2];
			fs_q   <= flags[3];
		end else if (can_emit) begin
			acc_q <= acc_q >> sfd_pkg::RAW_W;
		end else if (load) begin
			acc_q <= acc_q | (byte_ext << cnt_q);
		end
		if (can_emit) begin
			och_q   <= ch_q;
			oraw_q  <= acc_q[10:0];
			opw_q   <= sfd_pkg::pulse_of(acc_q[10:0]);
			olost_q <= lost_q;
			ofs_q   <= fs_q;
			olast_q <= (ch_q == sfd_pkg::LAST_CH);
		end
	end

	assign stat.busy  = busy_q;
	assign stat.shift = load;
	assign stat.done  = can_emit && (ch_q == sfd_pkg::LAST_CH);

	assign res.valid         = ov_q;
	assign res.channel_index = och_q;
	assign res.raw_value     = oraw_q;
	assign res.pulse_width   = opw_q;
	assign res.lost_flag     = olost_q;
	assign res.failsafe      = ofs_q;
	assign res.last          = olast_q;

endmodule

[hw/rtl/sbus_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// sbus_frame_decoder_core
// Hunts for the header, shifts the next 24 bytes (footer included) into a chain
// of byte cells, checks the footer and drains 16 channel items via the unpacker.
// ----------------------------------------------------------------------------
// Throughput: one rx byte per cycle while hunting or collecting a frame.
// After a good footer, rx ready drops for the drain: 16 items from 22 byte
// pulls from the chain; emits wait while the result side stalls. The first
// item follows once start sets the unpacker busy and it has pulled 11 bits.
// Reset: arst_n clears control to hunting; the byte chain holds no reset.
module sbus_frame_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	sfd_in_if.sink      rx_ch,
	sfd_out_if.source   res_ch
);

	sfd_pkg::state_t       state_q;
	logic [4:0]            count_q;
	sfd_pkg::unpack_stat_t stat;

	logic [7:0] chain [sfd_pkg::BODY_LEN+1];
	logic       rx_acc;
	logic       shift;
	logic       frame_end;
	logic       foot_ok;
	logic       start;

	assign rx_ch.ready = (state_q != sfd_pkg::ST_DRAIN);
	assign rx_acc      = rx_ch.valid && rx_ch.ready;
	assign frame_end   = rx_acc && (state_q == sfd_pkg::ST_COLLECT)
		&& (count_q == sfd_pkg::LAST_BODY);
	assign foot_ok     = (rx_ch.rx_byte == sfd_pkg::FOOT_A)
		|| (rx_ch.rx_byte == sfd_pkg::FOOT_B);
	assign start       = frame_end && foot_ok;
	assign shift       = (rx_acc && (state_q == sfd_pkg::ST_COLLECT)) || stat.shift;

	// bytes enter at the tail and walk toward the unpacker at cell 0
	assign chain[sfd_pkg::BODY_LEN] = rx_ch.rx_byte;

	for (genvar i = 0; i < sfd_pkg::BODY_LEN; i++) begin : g_cell
		sfd_byte_cell u_cell (
			.clk  (clk),
			.shift(shift),
			.din  (chain[i+1]),
			.dout (chain[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfd_pkg::ST_HUNT;
			count_q <= '0;
		end else begin
			case (state_q)
				sfd_pkg::ST_HUNT: begin
					if (rx_acc && rx_ch.rx_byte == sfd_pkg::HDR_BYTE) begin
						state_q <= sfd_pkg::ST_COLLECT;
						count_q <= '0;
					end
				end
				sfd_pkg::ST_COLLECT: begin
					if (frame_end) begin
						count_q <= '0;
						state_q <= foot_ok ? sfd_pkg::ST_DRAIN : sfd_pkg::ST_HUNT;
					end else if (rx_acc) begin
						count_q <= count_q + 5'd1;
					end
				end
				sfd_pkg::ST_DRAIN: begin
					if (stat.done) begin
						state_q <= sfd_pkg::ST_HUNT;
					end
				end
				default: begin
					state_q <= sfd_pkg::ST_HUNT;
					count_q <= '0;
				end
			endcase
		end
	end

	// flags byte sits in the last cell until the footer shifts it down
	sfd_unpack u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.flags    (chain[sfd_pkg::BODY_LEN-1]),
		.head_byte(chain[0]),
		.stat     (stat),
		.res      (res_ch)
	);

	a_last_is_ch15: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.last |-> res_ch.channel_index == sfd_pkg::LAST_CH)
		else $error("last marker on a channel other than 15");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid |-> (res_ch.pulse_width >= sfd_pkg::PW_BASE)
			&& (res_ch.pulse_width <= sfd_pkg::PW_TOP))
		else $error("pulse width out of range");

	a_done_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |=> state_q == sfd_pkg::ST_HUNT)
		else $error("drain finished without returning to hunt");

	a_busy_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> state_q == sfd_pkg::ST_DRAIN)
		else $error("unpacker busy outside of drain");

endmodule
